FILE: design/suvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suvd_pkg
// Shared widths, status codes and helpers for the surface UV derivative block.
// ----------------------------------------------------------------------------
package suvd_pkg;

   localparam int COMP_BITS  = 21;
   localparam int VEC_W      = 3 * COMP_BITS;
   localparam int PROD_W     = 2 * COMP_BITS;
   localparam int DOT_W      = PROD_W + 2;
   localparam int FRAC_SH    = 16;
   localparam int NUM_W      = DOT_W + FRAC_SH;
   localparam int DEN_W      = DOT_W;
   localparam int QUO_W      = 32;
   localparam int CMP_W      = DEN_W + QUO_W;
   localparam int TPROD_W    = QUO_W + COMP_BITS;
   localparam int FIELD_W    = 63;
   localparam int REQ_DATA_W = 8 * FIELD_W;
   localparam int RSP_DATA_W = 256;
   localparam int RSP_USER_W = 4;
   localparam int THR_W      = 32;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_DIFF = 2'd1,
      STATUS_FAIL    = 2'd2
   } status_type;

   function automatic logic signed [COMP_BITS-1:0] get_comp(logic [VEC_W-1:0] v, int k);
      return $signed(v[k*COMP_BITS +: COMP_BITS]);
   endfunction

   function automatic logic [COMP_BITS:0] abs_comp(logic signed [COMP_BITS-1:0] c);
      logic signed [COMP_BITS:0] e;
      e = (COMP_BITS+1)'(c);
      return e[COMP_BITS] ? (COMP_BITS+1)'(-e) : (COMP_BITS+1)'(e);
   endfunction

   function automatic logic [DOT_W-1:0] abs_dot(logic signed [DOT_W-1:0] v);
      return v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
   endfunction

   function automatic logic signed [COMP_BITS-1:0] sat_comp(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (COMP_BITS-1)) - 1;
      lo = -hi - 1;
      if (v > hi) return COMP_BITS'(hi);
      if (v < lo) return COMP_BITS'(lo);
      return COMP_BITS'(v);
   endfunction

endpackage
`default_nettype wire

FILE: design/suvd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suvd_div
// Pipelined restoring divider, one quotient bit per stage. Quotient must fit.
// ----------------------------------------------------------------------------
module suvd_div (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [suvd_pkg::NUM_W-1:0]  num_mag,
   input  wire logic [suvd_pkg::DEN_W-1:0]  den_mag,
   output logic      [suvd_pkg::QUO_W-1:0]  quo
);
   import suvd_pkg::*;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [NUM_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   always_comb begin
      logic [NUM_W-1:0] rc;
      logic [DEN_W-1:0] dc;
      logic [QUO_W-1:0] qc;
      logic [CMP_W:0]   diff;
      for (int j = 0; j < QUO_W; j++) begin
         rc = (j == 0) ? num_mag : rem_ff[(j == 0) ? 0 : j-1];
         dc = (j == 0) ? den_mag : den_ff[(j == 0) ? 0 : j-1];
         qc = (j == 0) ? '0 : quo_ff[(j == 0) ? 0 : j-1];
         diff = {1'b0, CMP_W'(rc)} - {1'b0, CMP_W'(dc) << (QUO_W-1-j)};
         if (!diff[CMP_W]) begin
            rem_in[j] = diff[NUM_W-1:0];
            quo_in[j] = qc | (QUO_W'(1) << (QUO_W-1-j));
         end else begin
            rem_in[j] = rc;
            quo_in[j] = qc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < QUO_W; j++) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= (j == 0) ? den_mag : den_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule
`default_nettype wire

FILE: design/surface_uv_derivatives.sv
`default_nettype none
// ----------------------------------------------------------------------------
// surface_uv_derivatives
// Ray differential plane hits and 2x2 UV derivative solve, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one hit per beat (normal, point, tangents, two offset rays).
//   rsp_*  : one result beat per request beat, in order.
//   csr_*  : det_threshold write; always ready, write only while idle.
// Pipeline: three set-up stages, a 32-stage divider for the ray parameters,
//   four solve stages, a second 32-stage divider for the derivatives, then
//   the output register; every stage is a register with a valid.
// Throughput: one beat per cycle unless the output stalls (see Stall).
// Stall: the whole pipeline freezes while rsp_tvalid is high and rsp_tready
//   low; req_tready drops in the same cycle. No beat is lost or repeated.
// Reset: clears all valids and sets det_threshold to 1.
// ----------------------------------------------------------------------------
module surface_uv_derivatives (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // normal_vec, hit_point, tangent_u, tangent_v, xray_origin, xray_dir,
   // yray_origin, yray_dir (63 bits each)
   input  wire logic [suvd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // has_diff
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // dp_dx(63), dp_dy(63), du_dx, dv_dx, du_dy, dv_dy (32 each), 2 zero bits
   output logic      [suvd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status(2), x_singular, y_singular
   output logic      [suvd_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [suvd_pkg::THR_W-1:0]       csr_data
);
   import suvd_pkg::*;

   localparam int OP_W = COMP_BITS + 1;

   typedef struct packed {
      logic                         has_diff;
      logic [VEC_W-1:0]             nvec;
      logic [VEC_W-1:0]             tu;
      logic [VEC_W-1:0]             tv;
      logic [VEC_W-1:0]             dir_x;
      logic [VEC_W-1:0]             dir_y;
      logic [2:0][OP_W-1:0]         op_x;
      logic [2:0][OP_W-1:0]         op_y;
      logic [2:0][PROD_W-1:0]       np;
      logic [2:0][PROD_W-1:0]       nox;
      logic [2:0][PROD_W-1:0]       ndx;
      logic [2:0][PROD_W-1:0]       noy;
      logic [2:0][PROD_W-1:0]       ndy;
   } s1_type;

   typedef struct packed {
      logic                         has_diff;
      logic [DOT_W-1:0]             num_x;
      logic [DOT_W-1:0]             den_x;
      logic [DOT_W-1:0]             num_y;
      logic [DOT_W-1:0]             den_y;
      logic [3:0][COMP_BITS-1:0]    a;
      logic [1:0]                   d0;
      logic [1:0]                   d1;
      logic [2:0][OP_W-1:0]         op_x;
      logic [2:0][OP_W-1:0]         op_y;
      logic [VEC_W-1:0]             dir_x;
      logic [VEC_W-1:0]             dir_y;
   } s2_type;

   typedef struct packed {
      logic                         has_diff;
      logic                         fail_x;
      logic                         sgn_x;
      logic                         fail_y;
      logic                         sgn_y;
      logic [2:0][OP_W-1:0]         op_x;
      logic [2:0][OP_W-1:0]         op_y;
      logic [VEC_W-1:0]             dir_x;
      logic [VEC_W-1:0]             dir_y;
      logic [3:0][COMP_BITS-1:0]    a;
      logic [1:0]                   d0;
      logic [1:0]                   d1;
      logic [PROD_W-1:0]            pa;
      logic [PROD_W-1:0]            pb;
   } pay1_type;

   typedef struct packed {
      logic [NUM_W-1:0]             nmag_x;
      logic [DEN_W-1:0]             dmag_x;
      logic [NUM_W-1:0]             nmag_y;
      logic [DEN_W-1:0]             dmag_y;
      pay1_type                     pay;
   } s3_type;

   typedef struct packed {
      logic                         has_diff;
      logic                         fail;
      logic [2:0][TPROD_W-1:0]      tdx;
      logic [2:0][TPROD_W-1:0]      tdy;
      logic [2:0][OP_W-1:0]         op_x;
      logic [2:0][OP_W-1:0]         op_y;
      logic [3:0][COMP_BITS-1:0]    a;
      logic [1:0]                   d0;
      logic [1:0]                   d1;
      logic [DOT_W-1:0]             det;
   } s4_type;

   typedef struct packed {
      logic                         has_diff;
      logic                         fail;
      logic [VEC_W-1:0]             dpx;
      logic [VEC_W-1:0]             dpy;
      logic [3:0][COMP_BITS-1:0]    a;
      logic [1:0]                   d0;
      logic [1:0]                   d1;
      logic [DOT_W-1:0]             det;
   } s5_type;

   typedef struct packed {
      logic                         has_diff;
      logic                         fail;
      logic                         sing;
      logic [VEC_W-1:0]             dpx;
      logic [VEC_W-1:0]             dpy;
      logic [DOT_W-1:0]             det;
      logic [7:0][PROD_W-1:0]       k;
   } s6_type;

   typedef struct packed {
      logic                         has_diff;
      logic                         fail;
      logic                         sing;
      logic [VEC_W-1:0]             dpx;
      logic [VEC_W-1:0]             dpy;
      logic [3:0]                   sgn;
      logic [3:0]                   ov;
   } pay2_type;

   typedef struct packed {
      logic [3:0][NUM_W-1:0]        nmag;
      logic [DEN_W-1:0]             dmag;
      pay2_type                     pay;
   } s7_type;

   logic                  adv;
   logic [THR_W-1:0]      thr_ff;

   s1_type   s1_in, s1_ff;
   s2_type   s2_in, s2_ff;
   s3_type   s3_in, s3_ff;
   s4_type   s4_in, s4_ff;
   s5_type   s5_in, s5_ff;
   s6_type   s6_in, s6_ff;
   s7_type   s7_in, s7_ff;
   pay1_type pay1_ff [QUO_W];
   pay2_type pay2_ff [QUO_W];

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic [QUO_W-1:0] vd1_ff, vd2_ff;

   logic [QUO_W-1:0] quo_x, quo_y;
   logic [3:0][QUO_W-1:0] quo_d;

   logic [RSP_DATA_W-1:0] rsp_tdata_in, rsp_tdata_ff;
   logic [RSP_USER_W-1:0] rsp_tuser_in, rsp_tuser_ff;
   logic                  rsp_tvalid_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // stage 1: per-component products, origin-to-hit differences
   always_comb begin
      logic [VEC_W-1:0] n, p, xo, xd, yo, yd;
      n  = req_tdata[0*FIELD_W +: VEC_W];
      p  = req_tdata[1*FIELD_W +: VEC_W];
      xo = req_tdata[4*FIELD_W +: VEC_W];
      xd = req_tdata[5*FIELD_W +: VEC_W];
      yo = req_tdata[6*FIELD_W +: VEC_W];
      yd = req_tdata[7*FIELD_W +: VEC_W];
      s1_in.has_diff = req_tuser;
      s1_in.nvec     = n;
      s1_in.tu       = req_tdata[2*FIELD_W +: VEC_W];
      s1_in.tv       = req_tdata[3*FIELD_W +: VEC_W];
      s1_in.dir_x    = xd;
      s1_in.dir_y    = yd;
      for (int k = 0; k < 3; k++) begin
         s1_in.op_x[k] = OP_W'(get_comp(xo, k)) - OP_W'(get_comp(p, k));
         s1_in.op_y[k] = OP_W'(get_comp(yo, k)) - OP_W'(get_comp(p, k));
         s1_in.np[k]   = get_comp(n, k) * get_comp(p, k);
         s1_in.nox[k]  = get_comp(n, k) * get_comp(xo, k);
         s1_in.ndx[k]  = get_comp(n, k) * get_comp(xd, k);
         s1_in.noy[k]  = get_comp(n, k) * get_comp(yo, k);
         s1_in.ndy[k]  = get_comp(n, k) * get_comp(yd, k);
      end
   end

   // stage 2: dot products, dominant axis
   always_comb begin
      logic signed [DOT_W-1:0] snp, snox, snoy;
      logic [COMP_BITS:0] an0, an1, an2;
      snp  = '0;
      snox = '0;
      snoy = '0;
      s2_in.den_x = '0;
      s2_in.den_y = '0;
      for (int k = 0; k < 3; k++) begin
         snp  = snp  + DOT_W'($signed(s1_ff.np[k]));
         snox = snox + DOT_W'($signed(s1_ff.nox[k]));
         snoy = snoy + DOT_W'($signed(s1_ff.noy[k]));
         s2_in.den_x = DOT_W'($signed(s2_in.den_x) + DOT_W'($signed(s1_ff.ndx[k])));
         s2_in.den_y = DOT_W'($signed(s2_in.den_y) + DOT_W'($signed(s1_ff.ndy[k])));
      end
      s2_in.num_x = snp - snox;
      s2_in.num_y = snp - snoy;
      an0 = abs_comp(get_comp(s1_ff.nvec, 0));
      an1 = abs_comp(get_comp(s1_ff.nvec, 1));
      an2 = abs_comp(get_comp(s1_ff.nvec, 2));
      if (an0 > an1 && an0 > an2) begin
         s2_in.d0 = 2'd1;
         s2_in.d1 = 2'd2;
      end else if (an1 > an2) begin
         s2_in.d0 = 2'd0;
         s2_in.d1 = 2'd2;
      end else begin
         s2_in.d0 = 2'd0;
         s2_in.d1 = 2'd1;
      end
      s2_in.a[0]     = get_comp(s1_ff.tu, int'(s2_in.d0));
      s2_in.a[1]     = get_comp(s1_ff.tv, int'(s2_in.d0));
      s2_in.a[2]     = get_comp(s1_ff.tu, int'(s2_in.d1));
      s2_in.a[3]     = get_comp(s1_ff.tv, int'(s2_in.d1));
      s2_in.has_diff = s1_ff.has_diff;
      s2_in.op_x     = s1_ff.op_x;
      s2_in.op_y     = s1_ff.op_y;
      s2_in.dir_x    = s1_ff.dir_x;
      s2_in.dir_y    = s1_ff.dir_y;
   end

   // stage 3: magnitudes, range check, determinant products
   always_comb begin
      s3_in.nmag_x = {abs_dot(s2_ff.num_x), FRAC_SH'(0)};
      s3_in.dmag_x = abs_dot(s2_ff.den_x);
      s3_in.nmag_y = {abs_dot(s2_ff.num_y), FRAC_SH'(0)};
      s3_in.dmag_y = abs_dot(s2_ff.den_y);
      s3_in.pay.has_diff = s2_ff.has_diff;
      s3_in.pay.fail_x   = (s2_ff.den_x == '0) ||
                           (CMP_W'(s3_in.nmag_x) >= {s3_in.dmag_x, QUO_W'(0)});
      s3_in.pay.fail_y   = (s2_ff.den_y == '0) ||
                           (CMP_W'(s3_in.nmag_y) >= {s3_in.dmag_y, QUO_W'(0)});
      s3_in.pay.sgn_x    = s2_ff.num_x[DOT_W-1] ^ s2_ff.den_x[DOT_W-1];
      s3_in.pay.sgn_y    = s2_ff.num_y[DOT_W-1] ^ s2_ff.den_y[DOT_W-1];
      s3_in.pay.op_x     = s2_ff.op_x;
      s3_in.pay.op_y     = s2_ff.op_y;
      s3_in.pay.dir_x    = s2_ff.dir_x;
      s3_in.pay.dir_y    = s2_ff.dir_y;
      s3_in.pay.a        = s2_ff.a;
      s3_in.pay.d0       = s2_ff.d0;
      s3_in.pay.d1       = s2_ff.d1;
      s3_in.pay.pa       = $signed(s2_ff.a[0]) * $signed(s2_ff.a[3]);
      s3_in.pay.pb       = $signed(s2_ff.a[1]) * $signed(s2_ff.a[2]);
   end

   suvd_div u_div_x (
      .clock   (clock),
      .en      (adv),
      .num_mag (s3_ff.nmag_x),
      .den_mag (s3_ff.dmag_x),
      .quo     (quo_x)
   );

   suvd_div u_div_y (
      .clock   (clock),
      .en      (adv),
      .num_mag (s3_ff.nmag_y),
      .den_mag (s3_ff.dmag_y),
      .quo     (quo_y)
   );

   // stage 4: signed t, t*d products, determinant
   always_comb begin
      pay1_type pq;
      logic signed [QUO_W-1:0] tx, ty;
      logic ovx, ovy;
      pq  = pay1_ff[QUO_W-1];
      tx  = pq.sgn_x ? -$signed(quo_x) : $signed(quo_x);
      ty  = pq.sgn_y ? -$signed(quo_y) : $signed(quo_y);
      ovx = pq.sgn_x ? (quo_x[QUO_W-1] && (|quo_x[QUO_W-2:0])) : quo_x[QUO_W-1];
      ovy = pq.sgn_y ? (quo_y[QUO_W-1] && (|quo_y[QUO_W-2:0])) : quo_y[QUO_W-1];
      for (int k = 0; k < 3; k++) begin
         s4_in.tdx[k] = tx * get_comp(pq.dir_x, k);
         s4_in.tdy[k] = ty * get_comp(pq.dir_y, k);
      end
      s4_in.has_diff = pq.has_diff;
      s4_in.fail     = pq.fail_x || pq.fail_y || ovx || ovy;
      s4_in.op_x     = pq.op_x;
      s4_in.op_y     = pq.op_y;
      s4_in.a        = pq.a;
      s4_in.d0       = pq.d0;
      s4_in.d1       = pq.d1;
      s4_in.det      = DOT_W'($signed(pq.pa)) - DOT_W'($signed(pq.pb));
   end

   // stage 5: plane hit offsets
   always_comb begin
      logic [TPROD_W-1:0] ax, ay;
      logic signed [TPROD_W-FRAC_SH-1:0] trx, try_;
      for (int k = 0; k < 3; k++) begin
         ax  = s4_ff.tdx[k] + (s4_ff.tdx[k][TPROD_W-1] ? TPROD_W'(65535) : TPROD_W'(0));
         ay  = s4_ff.tdy[k] + (s4_ff.tdy[k][TPROD_W-1] ? TPROD_W'(65535) : TPROD_W'(0));
         trx  = $signed(ax[TPROD_W-1:FRAC_SH]);
         try_ = $signed(ay[TPROD_W-1:FRAC_SH]);
         s5_in.dpx[k*COMP_BITS +: COMP_BITS] =
            sat_comp(longint'(trx) + longint'($signed(s4_ff.op_x[k])));
         s5_in.dpy[k*COMP_BITS +: COMP_BITS] =
            sat_comp(longint'(try_) + longint'($signed(s4_ff.op_y[k])));
      end
      s5_in.has_diff = s4_ff.has_diff;
      s5_in.fail     = s4_ff.fail;
      s5_in.a        = s4_ff.a;
      s5_in.d0       = s4_ff.d0;
      s5_in.d1       = s4_ff.d1;
      s5_in.det      = s4_ff.det;
   end

   // stage 6: cofactor products, singular test
   always_comb begin
      logic signed [COMP_BITS-1:0] bx0, bx1, by0, by1;
      bx0 = get_comp(s5_ff.dpx, int'(s5_ff.d0));
      bx1 = get_comp(s5_ff.dpx, int'(s5_ff.d1));
      by0 = get_comp(s5_ff.dpy, int'(s5_ff.d0));
      by1 = get_comp(s5_ff.dpy, int'(s5_ff.d1));
      s6_in.k[0] = $signed(s5_ff.a[3]) * bx0;
      s6_in.k[1] = $signed(s5_ff.a[1]) * bx1;
      s6_in.k[2] = $signed(s5_ff.a[0]) * bx1;
      s6_in.k[3] = $signed(s5_ff.a[2]) * bx0;
      s6_in.k[4] = $signed(s5_ff.a[3]) * by0;
      s6_in.k[5] = $signed(s5_ff.a[1]) * by1;
      s6_in.k[6] = $signed(s5_ff.a[0]) * by1;
      s6_in.k[7] = $signed(s5_ff.a[2]) * by0;
      s6_in.sing = (s5_ff.det == '0) ||
                   (64'(abs_dot(s5_ff.det)) < 64'(thr_ff));
      s6_in.has_diff = s5_ff.has_diff;
      s6_in.fail     = s5_ff.fail;
      s6_in.dpx      = s5_ff.dpx;
      s6_in.dpy      = s5_ff.dpy;
      s6_in.det      = s5_ff.det;
   end

   // stage 7: numerators, magnitudes, range check
   always_comb begin
      logic signed [DOT_W-1:0] nu;
      s7_in.dmag = abs_dot(s6_ff.det);
      for (int i = 0; i < 4; i++) begin
         nu = DOT_W'($signed(s6_ff.k[2*i])) - DOT_W'($signed(s6_ff.k[2*i+1]));
         s7_in.nmag[i]    = {abs_dot(nu), FRAC_SH'(0)};
         s7_in.pay.sgn[i] = nu[DOT_W-1] ^ s6_ff.det[DOT_W-1];
         s7_in.pay.ov[i]  = CMP_W'(s7_in.nmag[i]) >= {s7_in.dmag, QUO_W'(0)};
      end
      s7_in.pay.has_diff = s6_ff.has_diff;
      s7_in.pay.fail     = s6_ff.fail;
      s7_in.pay.sing     = s6_ff.sing;
      s7_in.pay.dpx      = s6_ff.dpx;
      s7_in.pay.dpy      = s6_ff.dpy;
   end

   for (genvar i = 0; i < 4; i++) begin : g_deriv
      suvd_div u_div (
         .clock   (clock),
         .en      (adv),
         .num_mag (s7_ff.nmag[i]),
         .den_mag (s7_ff.dmag),
         .quo     (quo_d[i])
      );
   end

   // output: sign, saturation, special cases
   always_comb begin
      pay2_type pq;
      logic [3:0][QUO_W-1:0] dv;
      logic big;
      pq = pay2_ff[QUO_W-1];
      for (int i = 0; i < 4; i++) begin
         big = pq.sgn[i] ? (quo_d[i][QUO_W-1] && (|quo_d[i][QUO_W-2:0]))
                         : quo_d[i][QUO_W-1];
         if (pq.sing) begin
            dv[i] = '0;
         end else if (pq.ov[i] || big) begin
            dv[i] = pq.sgn[i] ? {1'b1, (QUO_W-1)'(0)} : {1'b0, {(QUO_W-1){1'b1}}};
         end else begin
            dv[i] = pq.sgn[i] ? QUO_W'(-quo_d[i]) : quo_d[i];
         end
      end
      if (!pq.has_diff) begin
         rsp_tdata_in = '0;
         rsp_tuser_in = {2'b00, STATUS_NO_DIFF};
      end else if (pq.fail) begin
         rsp_tdata_in = '0;
         rsp_tuser_in = {2'b00, STATUS_FAIL};
      end else begin
         rsp_tdata_in = {2'b00, dv[3], dv[2], dv[1], dv[0],
                         FIELD_W'(pq.dpy), FIELD_W'(pq.dpx)};
         rsp_tuser_in = {pq.sing, pq.sing, STATUS_OK};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         pay1_ff[0] <= s3_ff.pay;
         pay2_ff[0] <= s7_ff.pay;
         for (int i = 1; i < QUO_W; i++) begin
            pay1_ff[i] <= pay1_ff[i-1];
            pay2_ff[i] <= pay2_ff[i-1];
         end
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         v6_ff         <= 1'b0;
         v7_ff         <= 1'b0;
         vd1_ff        <= '0;
         vd2_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff         <= req_tvalid;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         vd1_ff        <= {vd1_ff[QUO_W-2:0], v3_ff};
         v4_ff         <= vd1_ff[QUO_W-1];
         v5_ff         <= v4_ff;
         v6_ff         <= v5_ff;
         v7_ff         <= v6_ff;
         vd2_ff        <= {vd2_ff[QUO_W-2:0], v7_ff};
         rsp_tvalid_ff <= vd2_ff[QUO_W-1];
      end
   end

endmodule
`default_nettype wire

FILE: design/suvd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suvd_checker
// Port-level checks for the surface UV derivative block.
// ----------------------------------------------------------------------------
module suvd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [suvd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [suvd_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import suvd_pkg::*;

   // failed or no-differential beats carry nothing else
   a_special_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != STATUS_OK |-> rsp_tdata == '0 && rsp_tuser[3:2] == 2'b00)
      else $error("non-ok beat with payload");

   // both systems share one determinant
   a_sing_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2] == rsp_tuser[3])
      else $error("singular flags differ");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata[253:126] == '0)
      else $error("singular beat with derivatives");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output stall");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled beat changed");

endmodule

bind surface_uv_derivatives suvd_checker u_suvd_checker (.*);
`default_nettype wire
